// ===== src/iee_pkg.sv =====
// ----------------------------------------------------------------------------
// Infix evaluator package
// Shared types, operator codes and status codes of the expression evaluator.
// ----------------------------------------------------------------------------
package iee_pkg;

  localparam int unsigned StackDepth = 16;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned SpW        = $clog2(StackDepth);
  localparam int unsigned CntW       = $clog2(StackDepth + 1);
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned FifoAw     = $clog2(FifoDepth);

  typedef logic [2:0] op_t;
  localparam op_t OpLparen = 3'd0;
  localparam op_t OpAdd    = 3'd1;
  localparam op_t OpSub    = 3'd2;
  localparam op_t OpMul    = 3'd3;
  localparam op_t OpDiv    = 3'd4;

  typedef logic [1:0] status_t;
  localparam status_t StOk    = 2'd0;
  localparam status_t StDiv0  = 2'd1;
  localparam status_t StMal   = 2'd2;
  localparam status_t StOvf   = 2'd3;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_DIGIT  = 3'd1,
    KIND_LPAREN = 3'd2,
    KIND_RPAREN = 3'd3,
    KIND_OPER   = 3'd4
  } kind_e;

  // One classified item handed from the front to the back.
  typedef struct packed {
    kind_e      kind;
    op_t        op;
    logic [3:0] digit;
    logic       last;
  } token_t;

  localparam int unsigned TokW = $bits(token_t);

  function automatic logic prec_hi(op_t op);
    return (op == OpMul) || (op == OpDiv);
  endfunction

endpackage

// ===== src/iee_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module iee_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/iee_front.sv =====
// ----------------------------------------------------------------------------
// Evaluator front end
// Accepts characters, classifies them and queues tokens for the back end.
// ----------------------------------------------------------------------------
module iee_front import iee_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  logic [7:0] char_i,
  input  logic   last_i,
  output logic   tok_valid_o,
  input  logic   tok_ready_i,
  output token_t tok_o
);

  token_t             fifo_q [FifoDepth];
  logic [FifoAw-1:0]  wp_q, wp_d, rp_q, rp_d;
  logic [FifoAw:0]    cnt_q, cnt_d;
  token_t             tok_in;
  logic               push, pop;

  always_comb begin
    tok_in       = '0;
    tok_in.last  = last_i;
    tok_in.digit = 4'(char_i - 8'h30);
    tok_in.kind  = KIND_NONE;
    tok_in.op    = OpLparen;
    case (char_i)
      8'h28: tok_in.kind = KIND_LPAREN;
      8'h29: tok_in.kind = KIND_RPAREN;
      8'h2B: begin tok_in.kind = KIND_OPER; tok_in.op = OpAdd; end
      8'h2D: begin tok_in.kind = KIND_OPER; tok_in.op = OpSub; end
      8'h2A: begin tok_in.kind = KIND_OPER; tok_in.op = OpMul; end
      8'h2F: begin tok_in.kind = KIND_OPER; tok_in.op = OpDiv; end
      default: begin
        if (char_i >= 8'h30 && char_i <= 8'h39) begin
          tok_in.kind = KIND_DIGIT;
        end
      end
    endcase
  end

  assign in_ready_o  = (cnt_q != (FifoAw+1)'(FifoDepth));
  assign tok_valid_o = (cnt_q != '0);
  assign tok_o       = fifo_q[rp_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = tok_valid_o && tok_ready_i;

  always_comb begin
    wp_d  = push ? wp_q + 1'b1 : wp_q;
    rp_d  = pop ? rp_q + 1'b1 : rp_q;
    cnt_d = cnt_q + (FifoAw+1)'(push) - (FifoAw+1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= tok_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== src/iee_div.sv =====
// ----------------------------------------------------------------------------
// Iterative divider
// Signed division truncating toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module iee_div import iee_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [ValueWidth-1:0] a_i,
  input  logic [ValueWidth-1:0] b_i,
  output logic                  done_o,
  output logic [ValueWidth-1:0] q_o
);

  localparam int unsigned CW = $clog2(ValueWidth + 1);

  logic [ValueWidth-1:0] rem_q, quo_q, div_q;
  logic [CW-1:0]         cnt_q;
  logic                  busy_q, neg_q, done_q;
  logic [ValueWidth:0]   trial;
  logic [ValueWidth-1:0] ma, mb;

  assign ma    = a_i[ValueWidth-1] ? -a_i : a_i;
  assign mb    = b_i[ValueWidth-1] ? -b_i : b_i;
  assign trial = {rem_q, quo_q[ValueWidth-1]} - {1'b0, div_q};
  assign done_o = done_q;
  assign q_o   = neg_q ? -quo_q : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(ValueWidth);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= ma;
      div_q <= mb;
      neg_q <= a_i[ValueWidth-1] ^ b_i[ValueWidth-1];
    end else if (busy_q) begin
      if (!trial[ValueWidth]) begin
        rem_q <= trial[ValueWidth-1:0];
        quo_q <= {quo_q[ValueWidth-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[ValueWidth-2:0], quo_q[ValueWidth-1]};
        quo_q <= {quo_q[ValueWidth-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== src/iee_back.sv =====
// ----------------------------------------------------------------------------
// Evaluator back end
// Executes tokens on the two stacks and produces the final result.
// ----------------------------------------------------------------------------
module iee_back import iee_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  tok_valid_i,
  output logic                  tok_ready_o,
  input  token_t                tok_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output logic [ValueWidth-1:0] res_value_o,
  output status_t               res_status_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_PEEK, S_POPB, S_POPA, S_WAITA, S_EXEC, S_DIVW,
    S_CLOSE, S_DRAIN, S_FIN, S_FINW, S_OUT
  } state_e;

  state_e             state_q;
  token_t             tok_q;
  logic [CntW-1:0]    vcnt_q, ocnt_q;
  status_t            st_q;
  op_t                op_q;
  logic [ValueWidth-1:0] a_q, b_q;
  logic               out_v_q;
  logic [ValueWidth-1:0] out_val_q;
  status_t            out_st_q;

  logic               vwe, owe;
  logic [SpW-1:0]     vwa, vra, owa, ora;
  logic [ValueWidth-1:0] vwd, vrd;
  op_t                owd, ord;
  logic               div_start, div_done;
  logic [ValueWidth-1:0] div_q;
  logic [ValueWidth-1:0] mul_r;

  iee_ram #(.Width(ValueWidth), .Depth(StackDepth)) u_vram (
    .clk_i, .we_i(vwe), .waddr_i(vwa), .wdata_i(vwd), .raddr_i(vra), .rdata_o(vrd)
  );
  iee_ram #(.Width(3), .Depth(StackDepth)) u_oram (
    .clk_i, .we_i(owe), .waddr_i(owa), .wdata_i(owd), .raddr_i(ora), .rdata_o(ord)
  );
  iee_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .a_i(a_q), .b_i(b_q),
    .done_o(div_done), .q_o(div_q)
  );

  assign mul_r = ValueWidth'(a_q * b_q);

  // Read addresses point at the current tops, except in S_POPB, where the operand address is one below the top.
  assign ora = SpW'(ocnt_q - 1'b1);
  always_comb begin
    case (state_q)
      S_POPB:  vra = SpW'(vcnt_q - CntW'(2));
      default: vra = SpW'(vcnt_q - 1'b1);
    endcase
  end

  assign tok_ready_o  = (state_q == S_IDLE);
  assign res_valid_o  = out_v_q;
  assign res_value_o  = out_val_q;
  assign res_status_o = out_st_q;
  assign div_start    = (state_q == S_EXEC) && (op_q == OpDiv) && (b_q != '0);

  always_comb begin
    vwe = 1'b0; vwa = SpW'(vcnt_q); vwd = '0;
    owe = 1'b0; owa = SpW'(ocnt_q); owd = tok_q.op;
    case (state_q)
      S_DISPATCH: begin
        if (tok_q.kind == KIND_DIGIT && vcnt_q < CntW'(StackDepth)) begin
          vwe = 1'b1; vwd = ValueWidth'(tok_q.digit);
        end
      end
      S_PEEK: begin
        if ((tok_q.kind == KIND_OPER || tok_q.kind == KIND_LPAREN)
            && ocnt_q < CntW'(StackDepth)) begin
          owe = 1'b1;
          owd = (tok_q.kind == KIND_LPAREN) ? OpLparen : tok_q.op;
        end
      end
      S_EXEC: begin
        if (op_q != OpDiv) begin
          vwe = 1'b1;
          vwa = SpW'(vcnt_q);
          case (op_q)
            OpAdd:   vwd = a_q + b_q;
            OpSub:   vwd = a_q - b_q;
            default: vwd = mul_r;
          endcase
        end else if (b_q == '0) begin
          vwe = 1'b1; vwd = '0;
        end
      end
      S_DIVW: begin
        vwe = div_done; vwd = div_q;
      end
      default: ;
    endcase
  end

  function automatic status_t flag(status_t cur, status_t code);
    return (cur == StOk) ? code : cur;
  endfunction

  // S_CLOSE sees the operator top through the registered read port once its address has settled, and
  // S_PEEK pushes '(' or an operator. Reductions pop the operator, then read
  // b and a through the registered operand port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vcnt_q  <= '0;
      ocnt_q  <= '0;
      st_q    <= StOk;
      out_v_q <= 1'b0;
      tok_q   <= '0;
      op_q    <= OpLparen;
      a_q     <= '0;
      b_q     <= '0;
      out_val_q <= '0;
      out_st_q  <= StOk;
    end else begin
      if (res_valid_o && res_ready_i) begin
        out_v_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (tok_valid_i) begin
            tok_q   <= tok_i;
            state_q <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          case (tok_q.kind)
            KIND_DIGIT: begin
              if (vcnt_q < CntW'(StackDepth)) vcnt_q <= vcnt_q + 1'b1;
              else st_q <= flag(st_q, StOvf);
              state_q <= tok_q.last ? S_DRAIN : S_IDLE;
            end
            KIND_LPAREN: state_q <= S_PEEK;
            KIND_NONE:   state_q <= tok_q.last ? S_DRAIN : S_IDLE;
            default:     state_q <= S_CLOSE;
          endcase
        end
        S_CLOSE: begin
          // ord now shows the operator top.
          if (ocnt_q == '0) begin
            state_q <= (tok_q.kind == KIND_OPER) ? S_PEEK
                     : (tok_q.last ? S_DRAIN : S_IDLE);
          end else if (ord == OpLparen) begin
            if (tok_q.kind == KIND_RPAREN) begin
              ocnt_q  <= ocnt_q - 1'b1;
              state_q <= tok_q.last ? S_DRAIN : S_IDLE;
            end else begin
              state_q <= S_PEEK;
            end
          end else if (tok_q.kind == KIND_RPAREN
                       || prec_hi(ord) || !prec_hi(tok_q.op)) begin
            op_q    <= ord;
            ocnt_q  <= ocnt_q - 1'b1;
            state_q <= S_POPB;
          end else begin
            state_q <= S_PEEK;
          end
        end
        S_PEEK: begin
          // Push of '(' or an operator.
          if (ocnt_q < CntW'(StackDepth)) ocnt_q <= ocnt_q + 1'b1;
          else st_q <= flag(st_q, StOvf);
          state_q <= tok_q.last ? S_DRAIN : S_IDLE;
        end
        S_POPB: begin
          if (op_q == OpLparen || vcnt_q < CntW'(2)) begin
            st_q    <= flag(st_q, StMal);
            state_q <= tok_q.last && tok_q.kind == KIND_NONE ? S_DRAIN : S_WAITA;
            op_q    <= OpLparen;
          end else begin
            b_q     <= vrd;
            state_q <= S_POPA;
          end
        end
        S_POPA: begin
          a_q     <= vrd;
          vcnt_q  <= vcnt_q - CntW'(2);
          state_q <= S_EXEC;
        end
        S_WAITA: begin
          // After a reduction, done or discarded: resume the scan (or the drain).
          state_q <= (tok_q.kind == KIND_NONE && tok_q.last) ? S_DRAIN : S_CLOSE;
        end
        S_EXEC: begin
          if (op_q == OpDiv && b_q != '0) begin
            state_q <= S_DIVW;
          end else begin
            if (op_q == OpDiv) st_q <= flag(st_q, StDiv0);
            vcnt_q  <= vcnt_q + 1'b1;
            state_q <= S_WAITA;
          end
        end
        S_DIVW: begin
          if (div_done) begin
            vcnt_q  <= vcnt_q + 1'b1;
            state_q <= S_WAITA;
          end
        end
        S_DRAIN: begin
          // The drain reuses the reduction path; a marker token steers it back.
          tok_q.kind <= KIND_NONE;
          tok_q.last <= 1'b1;
          state_q    <= S_FIN;
        end
        S_FIN: begin
          if (ocnt_q != '0) begin
            op_q    <= ord;
            ocnt_q  <= ocnt_q - 1'b1;
            state_q <= S_POPB;
          end else begin
            state_q <= S_FINW;
          end
        end
        S_FINW: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_v_q) begin
            out_v_q   <= 1'b1;
            out_val_q <= (vcnt_q == '0) ? '0 : vrd;
            out_st_q  <= (vcnt_q == CntW'(1)) ? st_q : flag(st_q, StMal);
            vcnt_q    <= '0;
            ocnt_q    <= '0;
            st_q      <= StOk;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_vcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vcnt_q <= CntW'(StackDepth)) else $error("operand count out of range");
  a_ocnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q <= CntW'(StackDepth)) else $error("operator count out of range");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !res_ready_i |=> out_v_q && $stable(out_val_q))
    else $error("result dropped while stalled");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> vcnt_q == '0 && st_q == StOk)
    else $error("stacks not cleared after result");
`endif

endmodule

// ===== src/infix_expression_evaluator_top.sv =====
// The back end takes one token at a time and accepts the next only after it
// has finished with the last one; a division reduction waits on the
// bit-serial divider, which sets the worst-case rate. A result follows its
// last item once the operator stack has been drained.
// Items stream into a 4-entry token queue, so input continues while the back
// end reduces. Reset (rst_ni low, asynchronous) empties stacks, queue, status.
// ----------------------------------------------------------------------------
// Infix expression evaluator top
// Two-stack evaluator of single-digit infix expressions with status.
// ----------------------------------------------------------------------------
module infix_expression_evaluator_top import iee_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  input  logic        s_axis_tlast,   // last_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] result_value
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  logic   tok_valid, tok_ready;
  token_t tok;
  logic [ValueWidth-1:0] value;

  // The front end classifies each character and queues it as a token.
  iee_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .char_i(s_axis_tdata), .last_i(s_axis_tlast),
    .tok_valid_o(tok_valid), .tok_ready_i(tok_ready), .tok_o(tok)
  );

  // The back end runs the stacks and holds the result in its output register.
  iee_back u_back (
    .clk_i, .rst_ni,
    .tok_valid_i(tok_valid), .tok_ready_o(tok_ready), .tok_i(tok),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .res_value_o(value), .res_status_o(m_axis_tuser)
  );

  // The value is sign-extended or truncated to the 32-bit result field.
  assign m_axis_tdata = 32'(signed'(value));

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// Infix evaluator testbench
// Streams single-digit infix expressions into the evaluator, predicts each
// result and status with a two-stack model of its own, and checks every
// result item in order while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import iee_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] value;
    status_t     status;
  } answer_t;

  // Scoreboard: holds the evaluator state as predicted and the queue of
  // answers that are still due on the result stream.
  class expr_scoreboard;
    logic [31:0] vals[$];
    op_t         ops[$];
    status_t     sticky;
    answer_t     due[$];
    int          n_errors;
    int          n_answers;

    function void flag(status_t code);
      if (sticky == StOk) sticky = code;
    endfunction

    function void push_val(logic [31:0] v);
      if (vals.size() >= StackDepth) flag(StOvf);
      else vals.push_back(v);
    endfunction

    function void push_op(op_t op);
      if (ops.size() >= StackDepth) flag(StOvf);
      else ops.push_back(op);
    endfunction

    function bit is_hi(op_t op);
      return (op == OpMul) || (op == OpDiv);
    endfunction

    function logic [31:0] quotient(logic [31:0] a, logic [31:0] b);
      logic [31:0] ma, mb, q;
      if (b == 0) begin
        flag(StDiv0);
        return 32'd0;
      end
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      q  = ma / mb;
      return (a[31] != b[31]) ? -q : q;
    endfunction

    function void reduce_one();
      op_t         op;
      logic [31:0] a, b, r;
      if (ops.size() == 0) return;
      op = ops.pop_back();
      if (op == OpLparen || vals.size() < 2) begin
        flag(StMal);
        return;
      end
      b = vals.pop_back();
      a = vals.pop_back();
      case (op)
        OpAdd:   r = a + b;
        OpSub:   r = a - b;
        OpMul:   r = a * b;
        default: r = quotient(a, b);
      endcase
      vals.push_back(r);
    endfunction

    function void note_char(logic [7:0] ch, logic last);
      op_t     op;
      answer_t ans;
      if (ch >= "0" && ch <= "9") begin
        push_val(32'(ch - 8'h30));
      end else if (ch == "(") begin
        push_op(OpLparen);
      end else if (ch == ")") begin
        while (ops.size() > 0 && ops[$] != OpLparen) reduce_one();
        if (ops.size() > 0) void'(ops.pop_back());
      end else if (ch == "+" || ch == "-" || ch == "*" || ch == "/") begin
        op = (ch == "+") ? OpAdd : (ch == "-") ? OpSub : (ch == "*") ? OpMul : OpDiv;
        while (ops.size() > 0 && ops[$] != OpLparen && (!is_hi(op) || is_hi(ops[$])))
          reduce_one();
        push_op(op);
      end
      if (!last) return;
      while (ops.size() > 0) reduce_one();
      if (vals.size() == 0) begin
        flag(StMal);
        ans.value = 32'd0;
      end else begin
        if (vals.size() != 1) flag(StMal);
        ans.value = vals[$];
      end
      ans.status = sticky;
      due.push_back(ans);
      vals.delete();
      ops.delete();
      sticky = StOk;
    endfunction

    function void check_result(logic [31:0] value, status_t status);
      answer_t exp_a;
      n_answers++;
      if (due.size() == 0) begin
        $error("result with no expression pending: value %0h status %0d", value, status);
        n_errors++;
        return;
      end
      exp_a = due.pop_front();
      if (value !== exp_a.value) begin
        $error("result_value: expected %0h, got %0h", exp_a.value, value);
        n_errors++;
      end
      if (status !== exp_a.status) begin
        $error("status: expected %0d, got %0d", exp_a.status, status);
        n_errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;    // [7:0] char_in
  logic        s_axis_tlast;    // last_char
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;    // [31:0] result_value
  logic [1:0]  m_axis_tuser;    // [1:0] status

  expr_scoreboard sb = new();
  int  n_chars;
  int  n_exprs;
  int  sink_hold = 0; // Cycles left in a long stall of the result side.
  bit  sink_quiet;   // Stretches with the result side always ready.
  bit  src_quiet;    // Stretches with no gaps on the input side.

  infix_expression_evaluator_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Gap length: mostly zero or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Presents one character and holds it until the evaluator takes it. The
  // model is told at the edge of acceptance, so its queue leads the output.
  // Valid drops only for a gap, so back-to-back items keep it high.
  task automatic send_char(logic [7:0] ch, logic last);
    int g;
    g = src_quiet ? 0 : gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_char(ch, last);
    n_chars++;
    if (last) n_exprs++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] rand_digit();
    return 8'h30 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_oper();
    case ($urandom_range(0, 3))
      0:       return "+";
      1:       return "-";
      2:       return "*";
      default: return "/";
    endcase
  endfunction

  // A well-formed expression with random content and nesting. Depth is kept
  // low so that most expressions fit the stacks; a few are allowed to spill.
  function automatic string rand_expr(int depth);
    string s;
    int    terms;
    terms = $urandom_range(1, 5);
    s = "";
    for (int t = 0; t < terms; t++) begin
      if (t > 0) s = {s, string'(rand_oper())};
      if (depth > 0 && $urandom_range(0, 3) == 0)
        s = {s, "(", rand_expr(depth - 1), ")"};
      else
        s = {s, string'(rand_digit())};
    end
    return s;
  endfunction

  // Any character at all: covers every bit of char_in and the ignored set.
  function automatic string noise_expr();
    string s;
    string pool;
    int    len;
    pool = "0()+-*/9";
    len = $urandom_range(1, 12);
    s = "";
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 2) == 0) s = {s, string'(8'($urandom_range(0, 255)))};
      else s = {s, string'(pool[$urandom_range(0, 7)])};
    end
    return s;
  endfunction

  // Result side: random stalls, now and then a long one, with stretches of
  // constant readiness.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_hold = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
      if (sink_quiet) begin
        m_axis_tready <= 1'b1;
      end else if (sink_hold > 0) begin
        m_axis_tready <= 1'b0;
        sink_hold--;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) < 70);
        if ($urandom_range(0, 99) < 2) sink_hold = $urandom_range(10, 60);
      end
    end
  end

  initial begin
    string s;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    sink_quiet    = 1'b0;
    src_quiet     = 1'b0;
    n_chars       = 0;
    n_exprs       = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed expressions: precedence, grouping and each corner case.
    send_text("1+2*3");
    send_text("(1+2)*3");
    send_text("9-8-7");
    send_text("8/2/2");
    send_text("0-7/2");           // Truncation toward zero of 7/2 before the subtraction.
    send_text("5/0+1");           // Divide by zero gives a zero quotient.
    send_text("5/0+(");           // The first error seen is the one kept.
    send_text("(2+3");            // Unmatched opening parenthesis.
    send_text("2+3)*4");          // Unmatched closing parenthesis.
    send_text("+");               // Too few operands for a reduction.
    send_text("12");              // Two operands left at the end.
    send_text("x");               // Nothing but an ignored character.
    send_text("0-9*9*9*9*9*9*9*9*9*9*9"); // Wraps past 32 bits.
    send_text("0123456789012345678");     // Operand stack overflow.
    send_text("((((((((((((((((((1");     // Operator stack overflow.
    // A product that wraps to zero, then divided by minus one.
    send_text("(0-8*8*8*8*8*8*8*8*8*8*8)*2/(0-1)");
    send_text("9 * 9\t/ 3");

    // Random part: mostly well-formed, some noise and broken expressions.
    while (n_chars < 1280) begin
      if ($urandom_range(0, 19) == 0) begin
        src_quiet  = $urandom_range(0, 1);
        sink_quiet = $urandom_range(0, 1);
      end
      case ($urandom_range(0, 9))
        0:       s = noise_expr();
        1:       s = {rand_expr(2), string'(rand_oper())};
        2:       s = {"(", rand_expr(3)};
        default: s = rand_expr($urandom_range(0, 4));
      endcase
      send_text(s);
    end
    s_axis_tvalid <= 1'b0;

    while (sb.due.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Sent %0d characters in %0d expressions; %0d results checked.",
             n_chars, n_exprs, sb.n_answers);
    if (sb.n_errors == 0 && sb.due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== files.f =====
src/iee_pkg.sv
src/iee_ram.sv
src/iee_front.sv
src/iee_div.sv
src/iee_back.sv
src/infix_expression_evaluator_top.sv
tb/sv/tb.sv
